// File: rtl/core/tcs_pkg.sv
package tcs_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int STORE_DEPTH = 4096;

    localparam int HORNER_STEPS = 5;
    localparam logic [2:0] LAST_STEP = 3'(HORNER_STEPS - 1);

    localparam logic [24:0] ONE_L = 25'd16777216;
    localparam logic [24:0] HALF_L = 25'd8388608;
    localparam logic [21:0] ONE_S = 22'd2097152;
    localparam logic [21:0] HALF_PI = 22'd3294198;
    localparam logic [22:0] INTENSITY = 23'd7356705;
    localparam logic [27:0] DECAY = 28'd17;
    localparam logic [30:0] Q30_ONE = 31'd1073741824;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_WINDOW_LENGTH = 3'd0;
    localparam logic [2:0] REG_WINDOW_RECIP = 3'd1;
    localparam logic [2:0] REG_SLEW_GAIN = 3'd2;
    localparam logic [2:0] REG_SLEW_RECIP = 3'd3;
    localparam logic [2:0] REG_PREV_SLEW_WEIGHT = 3'd4;
    localparam logic [2:0] REG_BALANCE_WEIGHT = 3'd5;

    typedef struct packed {
        logic [11:0] window_length;
        logic [24:0] window_reciprocal;
        logic [24:0] slew_gain;
        logic [24:0] slew_gain_reciprocal;
        logic [24:0] prev_slew_weight;
        logic [31:0] balance_weight;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_ENTRY, OP_LVA, OP_LVB, OP_CLAMP,
        OP_SQ, OP_HMUL, OP_HDIV, OP_HFIX, OP_SFIN,
        OP_BL1, OP_BL2, OP_BL3, OP_SLEW, OP_SLEWM, OP_SLEWQ,
        OP_INT1, OP_INT2, OP_INT3, OP_CS1, OP_CS2, OP_CS3,
        OP_DRV, OP_DRVF, OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] step;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    // Series divisors of the Horner steps.
    function automatic logic [7:0] series_div(input logic vers, input logic [2:0] step);
        logic [7:0] d;
        case (step)
            3'd0: d = vers ? 8'd132 : 8'd110;
            3'd1: d = vers ? 8'd90 : 8'd72;
            3'd2: d = vers ? 8'd56 : 8'd42;
            3'd3: d = vers ? 8'd30 : 8'd20;
            default: d = vers ? 8'd12 : 8'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor); the quotient lands at most two below the true one.
    function automatic logic [29:0] series_recip(input logic vers, input logic [2:0] step);
        logic [29:0] m;
        case (step)
            3'd0: m = vers ? 30'd32537631 : 30'd39045157;
            3'd1: m = vers ? 30'd47721858 : 30'd59652323;
            3'd2: m = vers ? 30'd76695844 : 30'd102261126;
            3'd3: m = vers ? 30'd143165576 : 30'd214748364;
            default: m = vers ? 30'd357913941 : 30'd715827882;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/core/tcs_regs.sv
module tcs_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tcs_pkg::cfg_t      cfg
);

    tcs_pkg::cfg_t cfg_reg;
    tcs_pkg::cfg_t cfg_next;
    logic [2:0] index;
    logic wr_en;

    assign index = paddr[4:2];
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (index)
                tcs_pkg::REG_WINDOW_LENGTH: cfg_next.window_length = pwdata[11:0];
                tcs_pkg::REG_WINDOW_RECIP: cfg_next.window_reciprocal = pwdata[24:0];
                tcs_pkg::REG_SLEW_GAIN: cfg_next.slew_gain = pwdata[24:0];
                tcs_pkg::REG_SLEW_RECIP: cfg_next.slew_gain_reciprocal = pwdata[24:0];
                tcs_pkg::REG_PREV_SLEW_WEIGHT: cfg_next.prev_slew_weight = pwdata[24:0];
                tcs_pkg::REG_BALANCE_WEIGHT: cfg_next.balance_weight = pwdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (index)
            tcs_pkg::REG_WINDOW_LENGTH: prdata = {20'd0, cfg_reg.window_length};
            tcs_pkg::REG_WINDOW_RECIP: prdata = {7'd0, cfg_reg.window_reciprocal};
            tcs_pkg::REG_SLEW_GAIN: prdata = {7'd0, cfg_reg.slew_gain};
            tcs_pkg::REG_SLEW_RECIP: prdata = {7'd0, cfg_reg.slew_gain_reciprocal};
            tcs_pkg::REG_PREV_SLEW_WEIGHT: prdata = {7'd0, cfg_reg.prev_slew_weight};
            tcs_pkg::REG_BALANCE_WEIGHT: prdata = cfg_reg.balance_weight;
            default: prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_length <= 12'd549;
            cfg_reg.window_reciprocal <= 25'd30560;
            cfg_reg.slew_gain <= 25'd2147484;
            cfg_reg.slew_gain_reciprocal <= 25'd512000;
            cfg_reg.prev_slew_weight <= 25'd1761608;
            cfg_reg.balance_weight <= 32'd429497;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/tcs_ctrl.sv
module tcs_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  tcs_pkg::dp_status_t    status,
    output tcs_pkg::cmd_t          cmd
);

    typedef enum logic [24:0] {
        ST_IDLE  = 25'b1 << 0,
        ST_ENTRY = 25'b1 << 1,
        ST_LVA   = 25'b1 << 2,
        ST_LVB   = 25'b1 << 3,
        ST_CLAMP = 25'b1 << 4,
        ST_SQ    = 25'b1 << 5,
        ST_HMUL  = 25'b1 << 6,
        ST_HDIV  = 25'b1 << 7,
        ST_HFIX  = 25'b1 << 8,
        ST_SFIN  = 25'b1 << 9,
        ST_BL1   = 25'b1 << 10,
        ST_BL2   = 25'b1 << 11,
        ST_BL3   = 25'b1 << 12,
        ST_SLEW  = 25'b1 << 13,
        ST_SLEWM = 25'b1 << 14,
        ST_SLEWQ = 25'b1 << 15,
        ST_INT1  = 25'b1 << 16,
        ST_INT2  = 25'b1 << 17,
        ST_INT3  = 25'b1 << 18,
        ST_CS1   = 25'b1 << 19,
        ST_CS2   = 25'b1 << 20,
        ST_CS3   = 25'b1 << 21,
        ST_DRV   = 25'b1 << 22,
        ST_DRVF  = 25'b1 << 23,
        ST_DONE  = 25'b1 << 24
    } state_t;

    typedef enum logic [1:0] {
        CALL_BLEND, CALL_SLEW, CALL_DRIVE
    } call_t;

    state_t state_reg, state_next;
    call_t call_reg, call_next;
    logic [2:0] step_reg, step_next;
    tcs_pkg::op_t op;

    assign s_tready = (state_reg == ST_IDLE);
    assign cmd.op = op;
    assign cmd.step = step_reg;

    always_comb begin
        state_next = state_reg;
        call_next = call_reg;
        step_next = step_reg;
        op = tcs_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op = tcs_pkg::OP_LOAD;
                    state_next = ST_ENTRY;
                end
            end
            ST_ENTRY: begin op = tcs_pkg::OP_ENTRY; state_next = ST_LVA; end
            ST_LVA: begin op = tcs_pkg::OP_LVA; state_next = ST_LVB; end
            ST_LVB: begin op = tcs_pkg::OP_LVB; state_next = ST_CLAMP; end
            ST_CLAMP: begin
                op = tcs_pkg::OP_CLAMP;
                call_next = CALL_BLEND;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                op = tcs_pkg::OP_SQ;
                step_next = 3'd0;
                state_next = ST_HMUL;
            end
            ST_HMUL: begin op = tcs_pkg::OP_HMUL; state_next = ST_HDIV; end
            ST_HDIV: begin op = tcs_pkg::OP_HDIV; state_next = ST_HFIX; end
            ST_HFIX: begin
                op = tcs_pkg::OP_HFIX;
                if (step_reg == tcs_pkg::LAST_STEP) begin
                    state_next = ST_SFIN;
                end else begin
                    step_next = step_reg + 3'd1;
                    state_next = ST_HMUL;
                end
            end
            ST_SFIN: begin
                op = tcs_pkg::OP_SFIN;
                case (call_reg)
                    CALL_BLEND: state_next = ST_BL1;
                    CALL_SLEW: state_next = ST_SLEWQ;
                    default: state_next = ST_DRVF;
                endcase
            end
            ST_BL1: begin op = tcs_pkg::OP_BL1; state_next = ST_BL2; end
            ST_BL2: begin op = tcs_pkg::OP_BL2; state_next = ST_BL3; end
            ST_BL3: begin op = tcs_pkg::OP_BL3; state_next = ST_SLEW; end
            ST_SLEW: begin op = tcs_pkg::OP_SLEW; state_next = ST_SLEWM; end
            ST_SLEWM: begin
                op = tcs_pkg::OP_SLEWM;
                call_next = CALL_SLEW;
                state_next = ST_SQ;
            end
            ST_SLEWQ: begin op = tcs_pkg::OP_SLEWQ; state_next = ST_INT1; end
            ST_INT1: begin op = tcs_pkg::OP_INT1; state_next = ST_INT2; end
            ST_INT2: begin op = tcs_pkg::OP_INT2; state_next = ST_INT3; end
            ST_INT3: begin op = tcs_pkg::OP_INT3; state_next = ST_CS1; end
            ST_CS1: begin op = tcs_pkg::OP_CS1; state_next = ST_CS2; end
            ST_CS2: begin op = tcs_pkg::OP_CS2; state_next = ST_CS3; end
            ST_CS3: begin op = tcs_pkg::OP_CS3; state_next = ST_DRV; end
            ST_DRV: begin
                op = tcs_pkg::OP_DRV;
                call_next = CALL_DRIVE;
                state_next = ST_SQ;
            end
            ST_DRVF: begin op = tcs_pkg::OP_DRVF; state_next = ST_DONE; end
            ST_DONE: begin
                // Wait until the output register is free or being emptied.
                if (!status.out_busy) begin
                    op = tcs_pkg::OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            call_reg <= CALL_BLEND;
            step_reg <= 3'd0;
        end else begin
            state_reg <= state_next;
            call_reg <= call_next;
            step_reg <= step_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_ENTRY))
        else $error("accepted item did not start processing");

    a_horner_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HFIX && step_reg == tcs_pkg::LAST_STEP) |=> (state_reg == ST_SFIN))
        else $error("series evaluation ran past its last step");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == tcs_pkg::OP_EMIT) |-> !status.out_busy)
        else $error("result emitted over an item still waiting");

endmodule

// File: rtl/core/tcs_dp.sv
module tcs_dp #(
    parameter int STORE_DEPTH = tcs_pkg::STORE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tcs_pkg::cfg_t                     cfg,
    input  tcs_pkg::cmd_t                     cmd,
    output tcs_pkg::dp_status_t               status,
    input  logic [tcs_pkg::SAMPLE_BITS-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tcs_pkg::SAMPLE_BITS-1:0]   m_tdata
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = ((AW + 1 > 12) ? AW + 1 : 12) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
    localparam logic [AW-1:0] TOP_INDEX = AW'(STORE_DEPTH - 1);
    localparam logic [AW:0] FILL_FULL = (AW + 1)'(STORE_DEPTH);

    logic [23:0] level_store [STORE_DEPTH];

    // Pipeline and state registers.
    logic signed [23:0] x_reg, x_next;
    logic [23:0] ax_reg, ax_next;
    logic [23:0] entry_reg, entry_next;
    logic [23:0] rd_reg;
    logic old_self_reg, old_self_next, old_valid_reg, old_valid_next;
    logic [AW-1:0] wi_reg, wi_next;
    logic [AW:0] fill_reg, fill_next;
    logic [24:0] level_reg, level_next;
    logic signed [27:0] acc_reg, acc_next;
    logic [24:0] clamp_reg, clamp_next;
    logic [24:0] outw_reg, outw_next;
    logic [21:0] arg_reg, arg_next;
    logic vers_reg, vers_next;
    logic [31:0] x2_reg, x2_next;
    logic [30:0] t_reg, t_next;
    logic [31:0] p_reg, p_next;
    logic [29:0] q0_reg, q0_next;
    logic [21:0] sin_reg, sin_next;
    logic signed [49:0] bacc_reg, bacc_next;
    logic signed [23:0] y_reg, y_next;
    logic signed [23:0] ps_reg, ps_next;
    logic signed [24:0] s_reg, s_next;
    logic signed [26:0] d_reg, d_next;
    logic big_reg, big_next, pos_reg, pos_next;
    logic signed [23:0] sp_reg, sp_next;
    logic signed [27:0] lo_reg, lo_next;
    logic signed [28:0] tt_reg, tt_next;
    logic signed [25:0] po_reg, po_next;
    logic signed [25:0] v_reg, v_next;
    logic [21:0] c_reg, c_next;
    logic signed [24:0] t1_reg, t1_next;
    logic signed [23:0] slw_reg, slw_next;
    logic signed [27:0] v2_reg, v2_next;
    logic signed [23:0] res_reg, res_next;
    logic out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;

    // Store addressing.
    logic [CW-1:0] wl_e, kk, rsum;
    logic [AW-1:0] ri;

    assign wl_e = (cfg.window_length == 12'd0) ? CW'(1) : CW'(cfg.window_length);
    assign kk = (wl_e >= DEPTH_C) ? wl_e - DEPTH_C : wl_e;
    assign rsum = CW'(wi_reg) + kk;
    assign ri = (rsum >= DEPTH_C) ? AW'(rsum - DEPTH_C) : AW'(rsum);

    // Products, one per step.
    logic [46:0] ent_prod;
    logic [48:0] lva_prod, lvb_prod;
    logic [23:0] old_val;
    logic [30:0] xq;
    logic [61:0] sq_prod;
    logic [62:0] hm_prod;
    logic [61:0] hd_prod;
    logic [37:0] qd_prod;
    logic [52:0] sf_prod;
    logic [7:0] dc;
    logic [29:0] mc;
    logic [24:0] one_m_outw;
    logic signed [22:0] sr;
    logic signed [49:0] bl1_prod, bl3_prod;
    logic signed [48:0] bl2_prod;
    logic signed [50:0] bsum;
    logic [24:0] as_v;
    logic [49:0] sm_prod;
    logic [21:0] qv;
    logic [46:0] sq2_prod;
    logic signed [43:0] i1_prod, i2_prod;
    logic signed [44:0] i2sum;
    logic [23:0] ay;
    logic [47:0] cs1_prod;
    logic signed [46:0] cs2_prod;
    logic signed [50:0] cs3_prod;

    assign old_val = old_self_reg ? entry_reg : (old_valid_reg ? rd_reg : 24'd0);
    assign dc = tcs_pkg::series_div(vers_reg, cmd.step);
    assign mc = tcs_pkg::series_recip(vers_reg, cmd.step);
    assign xq = {arg_reg, 9'd0};
    assign one_m_outw = tcs_pkg::ONE_L - outw_reg;
    assign sr = (x_reg > 24'sd0) ? $signed({1'b0, sin_reg}) : -$signed({1'b0, sin_reg});
    assign as_v = (s_reg < 25'sd0) ? 25'(-s_reg) : 25'(s_reg);
    assign qv = big_reg ? tcs_pkg::ONE_S : sin_reg;
    assign ay = (y_reg < 24'sd0) ? 24'(-y_reg) : 24'(y_reg);

    assign ent_prod = ax_reg * tcs_pkg::INTENSITY;
    assign lva_prod = entry_reg * cfg.window_reciprocal;
    assign lvb_prod = old_val * cfg.window_reciprocal;
    assign sq_prod = xq * xq;
    assign hm_prod = x2_reg * t_reg;
    assign hd_prod = p_reg * mc;
    assign qd_prod = q0_reg * dc;
    assign sf_prod = arg_reg * t_reg;
    assign bl1_prod = x_reg * $signed({1'b0, one_m_outw});
    assign bl2_prod = sr * $signed({1'b0, outw_reg});
    assign bsum = bacc_reg + bl2_prod;
    assign bl3_prod = y_reg * $signed({1'b0, clamp_reg});
    assign sm_prod = as_v * cfg.slew_gain;
    assign sq2_prod = qv * cfg.slew_gain_reciprocal;
    assign i1_prod = d_reg * $signed({1'b0, cfg.balance_weight[15:0]});
    assign i2_prod = d_reg * $signed({1'b0, cfg.balance_weight[31:16]});
    assign i2sum = i2_prod + lo_reg;
    assign cs1_prod = ax_reg * ay;
    assign cs2_prod = slw_reg * $signed({1'b0, c_reg});
    assign cs3_prod = t1_reg * $signed({1'b0, cfg.prev_slew_weight});

    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    // Scratch values of the longer steps.
    logic signed [24:0] xe;
    logic [24:0] lvc, clampv;
    logic signed [27:0] over;
    logic signed [26:0] ow;
    logic [37:0] rr;
    logic [1:0] inc;
    logic [24:0] mv;
    logic [30:0] q2;
    logic signed [31:0] spv;
    logic signed [29:0] vv;
    logic [26:0] cq;
    logic signed [26:0] t2, w, aw_s;
    logic [22:0] dq;

    always_comb begin
        x_next = x_reg; ax_next = ax_reg; entry_next = entry_reg;
        old_self_next = old_self_reg; old_valid_next = old_valid_reg;
        wi_next = wi_reg; fill_next = fill_reg; level_next = level_reg;
        acc_next = acc_reg; clamp_next = clamp_reg; outw_next = outw_reg;
        arg_next = arg_reg; vers_next = vers_reg; x2_next = x2_reg; t_next = t_reg;
        p_next = p_reg; q0_next = q0_reg; sin_next = sin_reg; bacc_next = bacc_reg;
        y_next = y_reg; ps_next = ps_reg; s_next = s_reg; d_next = d_reg;
        big_next = big_reg; pos_next = pos_reg; sp_next = sp_reg; lo_next = lo_reg;
        tt_next = tt_reg; po_next = po_reg; v_next = v_reg; c_next = c_reg;
        t1_next = t1_reg; slw_next = slw_reg; v2_next = v2_reg; res_next = res_reg;
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        xe = '0; lvc = '0; clampv = '0; over = '0; ow = '0; rr = '0; inc = '0;
        mv = '0; q2 = '0; spv = '0; vv = '0; cq = '0; t2 = '0; w = '0; aw_s = '0; dq = '0;
        case (cmd.op)
            tcs_pkg::OP_LOAD: begin
                x_next = $signed(s_tdata);
                xe = {s_tdata[23], s_tdata};
                ax_next = (xe < 25'sd0) ? 24'(-xe) : 24'(xe);
            end
            tcs_pkg::OP_ENTRY: begin
                entry_next = {1'b0, ent_prod[46:24]};
                old_self_next = (kk == '0);
                old_valid_next = (kk <= CW'(fill_reg));
                wi_next = (wi_reg == '0) ? TOP_INDEX : wi_reg - 1'b1;
                if (fill_reg != FILL_FULL) begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            tcs_pkg::OP_LVA: begin
                acc_next = $signed({3'd0, level_reg}) + $signed(28'(lva_prod[48:21]))
                    - $signed(tcs_pkg::DECAY);
            end
            tcs_pkg::OP_LVB: begin
                acc_next = acc_reg - $signed(28'(lvb_prod[48:21]));
            end
            tcs_pkg::OP_CLAMP: begin
                clampv = tcs_pkg::ONE_L;
                if (acc_reg < 28'sd0) begin
                    lvc = '0;
                end else if (acc_reg > $signed({3'd0, tcs_pkg::ONE_L})) begin
                    lvc = tcs_pkg::ONE_L;
                    over = $signed({2'd0, tcs_pkg::ONE_L, 1'b0}) - acc_reg;
                    clampv = (over < $signed({3'd0, tcs_pkg::HALF_L})) ?
                        tcs_pkg::HALF_L : over[24:0];
                end else begin
                    lvc = acc_reg[24:0];
                end
                level_next = lvc;
                clamp_next = clampv;
                ow = $signed({2'd0, tcs_pkg::ONE_L}) - $signed({1'b0, lvc, 1'b0});
                vers_next = !(ow > 27'sd0);
                outw_next = (ow < 27'sd0) ? 25'(-ow) : 25'(ow);
                arg_next = (ax_reg > {2'd0, tcs_pkg::HALF_PI}) ? tcs_pkg::HALF_PI
                    : ax_reg[21:0];
            end
            tcs_pkg::OP_SQ: begin
                x2_next = sq_prod[61:30];
                t_next = tcs_pkg::Q30_ONE;
            end
            tcs_pkg::OP_HMUL: p_next = hm_prod[61:30];
            tcs_pkg::OP_HDIV: q0_next = hd_prod[61:32];
            tcs_pkg::OP_HFIX: begin
                // Remainder below three divisors: at most two corrections.
                rr = {6'd0, p_reg} - qd_prod;
                inc = {1'b0, rr >= {30'd0, dc}} + {1'b0, rr >= {29'd0, dc, 1'b0}};
                t_next = tcs_pkg::Q30_ONE - ({1'b0, q0_reg} + {29'd0, inc});
            end
            tcs_pkg::OP_SFIN: begin
                sin_next = vers_reg ? hm_prod[61:40] : sf_prod[51:30];
            end
            tcs_pkg::OP_BL1: bacc_next = bl1_prod;
            tcs_pkg::OP_BL2: y_next = bsum[47:24];
            tcs_pkg::OP_BL3: y_next = bl3_prod[47:24];
            tcs_pkg::OP_SLEW: begin
                s_next = {y_reg[23], y_reg} - {ps_reg[23], ps_reg};
                ps_next = y_reg;
                d_next = {po_reg[25], po_reg} - 27'(y_reg);
            end
            tcs_pkg::OP_SLEWM: begin
                mv = sm_prod[48:24];
                big_next = mv > {3'd0, tcs_pkg::HALF_PI};
                arg_next = (mv > {3'd0, tcs_pkg::HALF_PI}) ? tcs_pkg::HALF_PI : mv[21:0];
                vers_next = 1'b0;
                pos_next = s_reg > 25'sd0;
            end
            tcs_pkg::OP_SLEWQ: begin
                q2 = sq2_prod[46:16];
                spv = pos_reg ? $signed({1'b0, q2}) : -$signed({1'b0, q2});
                if (spv > 32'sd8388607) begin
                    sp_next = 24'sd8388607;
                end else if (spv < -32'sd8388608) begin
                    sp_next = -24'sd8388608;
                end else begin
                    sp_next = spv[23:0];
                end
            end
            tcs_pkg::OP_INT1: lo_next = i1_prod[43:16];
            tcs_pkg::OP_INT2: tt_next = i2sum[44:16];
            tcs_pkg::OP_INT3: begin
                vv = 30'(po_reg) - 30'(tt_reg) + 30'(sp_reg);
                if (vv > 30'sd33554431) begin
                    v_next = 26'sd33554431;
                end else if (vv < -30'sd33554432) begin
                    v_next = -26'sd33554432;
                end else begin
                    v_next = vv[25:0];
                end
                po_next = v_next;
            end
            tcs_pkg::OP_CS1: begin
                cq = cs1_prod[47:21];
                c_next = (cq > {5'd0, tcs_pkg::ONE_S}) ? tcs_pkg::ONE_S : cq[21:0];
            end
            tcs_pkg::OP_CS2: t1_next = cs2_prod[45:21];
            tcs_pkg::OP_CS3: begin
                t2 = cs3_prod[50:24];
                v2_next = 28'(v_reg) - 28'(t2);
                slw_next = sp_reg;
            end
            tcs_pkg::OP_DRV: begin
                w = v2_reg[27:1];
                aw_s = (w < 27'sd0) ? -w : w;
                big_next = aw_s > $signed({5'd0, tcs_pkg::HALF_PI});
                arg_next = (aw_s > $signed({5'd0, tcs_pkg::HALF_PI})) ? tcs_pkg::HALF_PI
                    : aw_s[21:0];
                vers_next = 1'b0;
                pos_next = w > 27'sd0;
            end
            tcs_pkg::OP_DRVF: begin
                dq = {qv, 1'b0};
                res_next = pos_reg ? $signed({1'b0, dq}) : -$signed({1'b0, dq});
            end
            tcs_pkg::OP_EMIT: begin
                out_data_next = res_reg;
                out_valid_next = 1'b1;
            end
            default: out_data_next = out_data_reg;
        endcase
    end

    // The old entry is captured at the write cycle, before the index steps on.
    always_ff @(posedge aclk) begin
        if (cmd.op == tcs_pkg::OP_ENTRY) begin
            level_store[wi_reg] <= entry_next;
            rd_reg <= level_store[ri];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wi_reg <= TOP_INDEX;
            fill_reg <= '0;
            level_reg <= '0;
            ps_reg <= '0;
            po_reg <= '0;
            slw_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            wi_reg <= wi_next;
            fill_reg <= fill_next;
            level_reg <= level_next;
            ps_reg <= ps_next;
            po_reg <= po_next;
            slw_reg <= slw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next; ax_reg <= ax_next; entry_reg <= entry_next;
        old_self_reg <= old_self_next; old_valid_reg <= old_valid_next;
        acc_reg <= acc_next; clamp_reg <= clamp_next; outw_reg <= outw_next;
        arg_reg <= arg_next; vers_reg <= vers_next; x2_reg <= x2_next; t_reg <= t_next;
        p_reg <= p_next; q0_reg <= q0_next; sin_reg <= sin_next; bacc_reg <= bacc_next;
        y_reg <= y_next; s_reg <= s_next; d_reg <= d_next;
        big_reg <= big_next; pos_reg <= pos_next; sp_reg <= sp_next; lo_reg <= lo_next;
        tt_reg <= tt_next; v_reg <= v_next; c_reg <= c_next; t1_reg <= t1_next;
        v2_reg <= v2_next; res_reg <= res_next; out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/core/tube_console_saturator.sv
// An accepted item passes the level, blend, slew and drive steps before its result.
// A new item is taken only once the last result is in the output register; three
// series evaluations on the shared Horner unit take most of the time of an item.
// The output register lets the next item enter while a result waits to be taken.
// Reset (aresetn low, synchronous) clears the control state, the level and history
// values and the fill count of the level store, and loads the register defaults.
module tube_console_saturator #(
    parameter int STORE_DEPTH = tcs_pkg::STORE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tcs_pkg::SAMPLE_BITS-1:0]   s_tdata,  // [23:0] sample_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tcs_pkg::SAMPLE_BITS-1:0]   m_tdata,  // [23:0] sample_out
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [4:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    tcs_pkg::cfg_t cfg;
    tcs_pkg::cmd_t cmd;
    tcs_pkg::dp_status_t status;

    tcs_regs u_regs (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .cfg(cfg)
    );

    tcs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .status(status), .cmd(cmd)
    );

    tcs_dp #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg), .cmd(cmd), .status(status),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule
